@@ rtl/core/slfd_pkg.sv @@
// ----------------------------------------------------------------------------
// slfd_pkg
// Shared types and constants of the sync/length frame deframer: result kinds,
// header codes, register indexes and reset values of the configuration.
// ----------------------------------------------------------------------------
package slfd_pkg;

  // Default receive buffer depth in bytes
  localparam int unsigned BufferBytesDefault = 1024;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned MaxLenW = 11;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned FlenW   = 11;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // Configuration reset values
  localparam logic [ByteW-1:0]   SyncFirstReset  = 8'd90;
  localparam logic [ByteW-1:0]   SyncSecondReset = 8'd73;
  localparam logic [MaxLenW-1:0] MaxLenReset     = 11'd1000;

  // Header and terminator characters
  localparam logic [ByteW-1:0] AsciiQual = 8'h41;
  localparam logic [ByteW-1:0] AsciiLen  = 8'h33;
  localparam logic [ByteW-1:0] ChLf      = 8'h0A;
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    RegSyncFirst  = 2'd0,
    RegSyncSecond = 2'd1,
    RegMaxLength  = 2'd2
  } reg_idx_e;

  // Result kinds
  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindAsciiEnd = 2'd1,
    KindAbort    = 2'd2
  } kind_e;

  // Deframer phases, one-hot
  typedef enum logic [6:0] {
    PhHunt  = 7'b0000001,
    PhSync2 = 7'b0000010,
    PhQual  = 7'b0000100,
    PhLenLo = 7'b0001000,
    PhLenHi = 7'b0010000,
    PhBin   = 7'b0100000,
    PhAscii = 7'b1000000
  } phase_e;

endpackage

@@ rtl/core/slfd_if.sv @@
// ----------------------------------------------------------------------------
// slfd_in_if / slfd_out_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface slfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [slfd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfd_out_if;
  logic                         valid;
  logic                         ready;
  slfd_pkg::kind_e              kind;
  logic [slfd_pkg::ByteW-1:0]   byte_value;
  logic [slfd_pkg::IndexW-1:0]  byte_index;
  logic                         end_of_frame;
  logic [slfd_pkg::FlenW-1:0]   frame_length;
  logic [slfd_pkg::ByteW-1:0]   qualifier;
  logic                         ascii_frame;

  modport source (output valid, output kind, output byte_value, output byte_index,
                  output end_of_frame, output frame_length, output qualifier,
                  output ascii_frame, input ready);
  modport sink   (input valid, input kind, input byte_value, input byte_index,
                  input end_of_frame, input frame_length, input qualifier,
                  input ascii_frame, output ready);
endinterface

@@ rtl/core/sync_length_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_unit
// Hunts for two sync bytes, latches qualifier and length, then emits payload
// bytes of binary frames, or of ascii frames ended by LF then CR; also end and abort results.
// ----------------------------------------------------------------------------
// Results are registered: a result appears on res_o in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a result waits untaken; the single state update per byte sets it.
// A waiting result does not block the next byte while res_o.ready is high.
// Reset: asynchronous, active low; hunting for the first sync byte,
// configuration back to its defaults, no result pending.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_unit #(
  parameter int unsigned BufferBytes = slfd_pkg::BufferBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slfd_pkg::AddrW-1:0]    paddr,
  input  logic [slfd_pkg::DataW-1:0]    pwdata,
  output logic [slfd_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // streams
  slfd_in_if.sink                       rx_i,
  slfd_out_if.source                    res_o
);
  import slfd_pkg::*;

  localparam int unsigned CntW = $clog2(BufferBytes + 1);
  localparam int unsigned CmpW = ((CntW > LenW) ? CntW : LenW) + 1;
  localparam logic [CmpW-1:0] BufLimit = CmpW'(BufferBytes);

  // Configuration registers
  logic [ByteW-1:0]   sync_first_q, sync_second_q;
  logic [MaxLenW-1:0] max_len_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  // Write configuration on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
      max_len_q     <= MaxLenReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegSyncFirst:  sync_first_q  <= pwdata[ByteW-1:0];
        RegSyncSecond: sync_second_q <= pwdata[ByteW-1:0];
        RegMaxLength:  max_len_q     <= pwdata[MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      RegSyncFirst:  prdata = DataW'(sync_first_q);
      RegSyncSecond: prdata = DataW'(sync_second_q);
      RegMaxLength:  prdata = DataW'(max_len_q);
      default:       prdata = '0;
    endcase
  end

  // Deframer state
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  qual_q, qual_d;
  logic [ByteW-1:0]  len_lo_q, len_lo_d;
  logic [LenW-1:0]   exp_len_q, exp_len_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ByteW-1:0]  held_q, held_d;
  logic              held_vld_q, held_vld_d;

  // Result register
  logic              out_vld_q, out_vld_d;
  kind_e             kind_q, kind_d;
  logic [ByteW-1:0]  val_q, val_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic              eof_q, eof_d;
  logic [FlenW-1:0]  flen_q, flen_d;
  logic [ByteW-1:0]  oqual_q;
  logic              ascii_q, ascii_d;
  logic              emit;

  logic              accept;
  logic [ByteW-1:0]  b;
  logic [CmpW-1:0]   cnt_ext, cnt_inc, new_len, exp_ext;
  logic              hunt_hit;

  assign rx_i.ready = ~out_vld_q | res_o.ready;
  assign accept     = rx_i.valid & rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign cnt_ext    = CmpW'(cnt_q);
  assign cnt_inc    = cnt_ext + CmpW'(1);
  assign new_len    = CmpW'({b, len_lo_q});
  assign exp_ext    = CmpW'(exp_len_q);
  assign hunt_hit   = (b == sync_first_q);

  // Next state and result for one received byte
  always_comb begin
    phase_d    = phase_q;
    qual_d     = qual_q;
    len_lo_d   = len_lo_q;
    exp_len_d  = exp_len_q;
    cnt_d      = cnt_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    emit       = 1'b0;
    kind_d     = KindPayload;
    val_d      = '0;
    idx_d      = '0;
    eof_d      = 1'b0;
    flen_d     = '0;
    ascii_d    = 1'b0;
    case (phase_q)
      PhSync2: begin
        phase_d = (b == sync_second_q) ? PhQual : PhHunt;
      end
      PhQual: begin
        qual_d  = b;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_lo_d = b;
        phase_d  = PhLenHi;
      end
      PhLenHi: begin
        exp_len_d  = {b, len_lo_q};
        cnt_d      = '0;
        held_vld_d = 1'b0;
        if (qual_q != AsciiQual) begin
          if (new_len >= CmpW'(max_len_q) || new_len > BufLimit) phase_d = PhHunt;
          else phase_d = PhBin;
        end else begin
          if (len_lo_q != AsciiLen || b != AsciiLen) phase_d = PhHunt;
          else phase_d = PhAscii;
        end
      end
      PhBin: begin
        emit = 1'b1;
        if (exp_len_q == '0) begin
          // zero length: swallow the byte and abort
          phase_d = PhHunt;
          kind_d  = KindAbort;
        end else begin
          val_d = b;
          idx_d = cnt_ext[IndexW-1:0];
          cnt_d = cnt_inc[CntW-1:0];
          if (cnt_inc >= exp_ext) begin
            phase_d = PhHunt;
            eof_d   = 1'b1;
            flen_d  = exp_len_q[FlenW-1:0];
          end
        end
      end
      PhAscii: begin
        if (!held_vld_q) begin
          held_d     = b;
          held_vld_d = 1'b1;
        end else if (held_q == ChLf && b == ChCr) begin
          // terminator: close frame, rehunt on this byte
          emit       = 1'b1;
          kind_d     = KindAsciiEnd;
          flen_d     = cnt_ext[FlenW-1:0];
          ascii_d    = 1'b1;
          held_vld_d = 1'b0;
          phase_d    = hunt_hit ? PhSync2 : PhHunt;
        end else if (cnt_inc >= BufLimit) begin
          // buffer overflow: abort, rehunt on this byte
          emit       = 1'b1;
          kind_d     = KindAbort;
          ascii_d    = 1'b1;
          held_vld_d = 1'b0;
          phase_d    = hunt_hit ? PhSync2 : PhHunt;
        end else begin
          emit    = 1'b1;
          val_d   = held_q;
          idx_d   = cnt_ext[IndexW-1:0];
          ascii_d = 1'b1;
          cnt_d   = cnt_inc[CntW-1:0];
          held_d  = b;
        end
      end
      default: begin
        phase_d = hunt_hit ? PhSync2 : PhHunt;
      end
    endcase
  end

  // Hold a result until taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (accept && emit) out_vld_d = 1'b1;
    else if (res_o.ready) out_vld_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHunt;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (accept) begin
        phase_q    <= phase_d;
        held_vld_q <= held_vld_d;
      end
    end
  end

  // Frame data and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qual_q    <= qual_d;
      len_lo_q  <= len_lo_d;
      exp_len_q <= exp_len_d;
      cnt_q     <= cnt_d;
      held_q    <= held_d;
    end
    if (accept && emit) begin
      kind_q  <= kind_d;
      val_q   <= val_d;
      idx_q   <= idx_d;
      eof_q   <= eof_d;
      flen_q  <= flen_d;
      oqual_q <= qual_q;
      ascii_q <= ascii_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.kind         = kind_q;
  assign res_o.byte_value   = val_q;
  assign res_o.byte_index   = idx_q;
  assign res_o.end_of_frame = eof_q;
  assign res_o.frame_length = flen_q;
  assign res_o.qualifier    = oqual_q;
  assign res_o.ascii_frame  = ascii_q;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync/length frame deframer. Received bytes go in
// through the valid/ready request channel; every accepted byte is run through a
// local deframer model, and each result leaving the block is compared field by
// field with the oldest predicted one. Directed frames cover the header cases,
// then random traffic runs under three idle patterns and several register
// settings, with one long receiver stall and one ascii buffer overflow.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slfd_pkg::*;

  localparam int unsigned BufBytes     = BufferBytesDefault;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  byte_value;
    logic [IndexW-1:0] byte_index;
    logic              end_of_frame;
    logic [FlenW-1:0]  frame_length;
    logic [ByteW-1:0]  qualifier;
    logic              ascii_frame;
  } deframe_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  slfd_in_if  rx_bus ();
  slfd_out_if res_bus ();

  sync_length_frame_deframer_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx_i    (rx_bus),
    .res_o   (res_bus)
  );

  // Register copies and deframer state of the local model
  logic [ByteW-1:0]   cfg_sync_first  = SyncFirstReset;
  logic [ByteW-1:0]   cfg_sync_second = SyncSecondReset;
  logic [MaxLenW-1:0] cfg_max_len     = MaxLenReset;

  phase_e             dfr_phase      = PhHunt;
  logic [ByteW-1:0]   dfr_qual       = '0;
  logic [ByteW-1:0]   dfr_len_lo     = '0;
  logic [LenW-1:0]    dfr_len        = '0;
  logic [10:0]        dfr_count      = '0;
  logic [ByteW-1:0]   dfr_held       = '0;
  logic               dfr_held_valid = 1'b0;

  deframe_result_t    expected_results[$];
  int unsigned        fail_count    = 0;
  int unsigned        bytes_sent    = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        hold_starts   = 0;

  always #5 clk_i = ~clk_i;

  // Advance the model by one received byte; return 1 when it yields a result
  function automatic bit deframe_step(input logic [ByteW-1:0] b,
                                      output deframe_result_t r);
    bit hit;
    bit term;
    hit = 1'b0;
    r   = '0;
    r.qualifier = dfr_qual;
    case (dfr_phase)
      PhSync2: begin
        if (b == cfg_sync_second) dfr_phase = PhQual;
        else dfr_phase = PhHunt;
      end
      PhQual: begin
        dfr_qual  = b;
        dfr_phase = PhLenLo;
      end
      PhLenLo: begin
        dfr_len_lo = b;
        dfr_phase  = PhLenHi;
      end
      PhLenHi: begin
        dfr_len        = {b, dfr_len_lo};
        dfr_count      = '0;
        dfr_held_valid = 1'b0;
        if (dfr_qual != AsciiQual) begin
          if (dfr_len >= LenW'(cfg_max_len) || dfr_len > LenW'(BufBytes)) dfr_phase = PhHunt;
          else dfr_phase = PhBin;
        end else begin
          if (dfr_len_lo == AsciiLen && b == AsciiLen) dfr_phase = PhAscii;
          else dfr_phase = PhHunt;
        end
      end
      PhBin: begin
        hit = 1'b1;
        if (dfr_len == '0) begin
          // zero length: swallow this byte and abort
          r.kind    = KindAbort;
          dfr_phase = PhHunt;
        end else begin
          r.kind       = KindPayload;
          r.byte_value = b;
          r.byte_index = dfr_count[IndexW-1:0];
          dfr_count    = dfr_count + 11'd1;
          if (LenW'(dfr_count) >= dfr_len) begin
            r.end_of_frame = 1'b1;
            r.frame_length = dfr_len[FlenW-1:0];
            dfr_phase      = PhHunt;
          end
        end
      end
      PhAscii: begin
        if (!dfr_held_valid) begin
          dfr_held       = b;
          dfr_held_valid = 1'b1;
        end else begin
          hit           = 1'b1;
          r.ascii_frame = 1'b1;
          term          = (dfr_held == ChLf && b == ChCr);
          if (term || int'(dfr_count) + 1 >= int'(BufBytes)) begin
            // terminator or overflow; the trigger byte is hunted again
            if (term) begin
              r.kind         = KindAsciiEnd;
              r.frame_length = dfr_count;
            end else begin
              r.kind = KindAbort;
            end
            if (b == cfg_sync_first) dfr_phase = PhSync2;
            else dfr_phase = PhHunt;
            dfr_held_valid = 1'b0;
          end else begin
            r.kind       = KindPayload;
            r.byte_value = dfr_held;
            r.byte_index = dfr_count[IndexW-1:0];
            dfr_count    = dfr_count + 11'd1;
            dfr_held     = b;
          end
        end
      end
      default: begin
        if (b == cfg_sync_first) dfr_phase = PhSync2;
        else dfr_phase = PhHunt;
      end
    endcase
    return hit;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on each accepted byte, then compare each accepted result
  always @(posedge clk_i) begin
    deframe_result_t next_r;
    deframe_result_t want_r;
    if (rst_ni) begin
      if (rx_bus.valid && rx_bus.ready) begin
        if (deframe_step(rx_bus.rx_byte, next_r)) expected_results.push_back(next_r);
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no pending expectation");
          fail_count++;
        end else begin
          want_r = expected_results.pop_front();
          check_field("kind", want_r.kind, res_bus.kind);
          check_field("byte_value", want_r.byte_value, res_bus.byte_value);
          check_field("byte_index", want_r.byte_index, res_bus.byte_index);
          check_field("end_of_frame", want_r.end_of_frame, res_bus.end_of_frame);
          check_field("frame_length", want_r.frame_length, res_bus.frame_length);
          check_field("qualifier", want_r.qualifier, res_bus.qualifier);
          check_field("ascii_frame", want_r.ascii_frame, res_bus.ascii_frame);
        end
      end
    end
  end

  // Result receiver: random idling, or a long hold when one is requested
  initial begin
    int unsigned served;
    served = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != hold_starts) begin
        served = hold_starts;
        res_bus.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [ByteW-1:0] qual, input logic [ByteW-1:0] len_lo,
                             input logic [ByteW-1:0] len_hi);
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    send_byte(qual);
    send_byte(len_lo);
    send_byte(len_hi);
  endtask

  // Binary frame; payload only follows a header that the block will take
  task automatic send_binary_frame(input logic [ByteW-1:0] qual, input logic [LenW-1:0] len);
    send_header(qual, len[7:0], len[15:8]);
    if (len < LenW'(cfg_max_len) && len <= LenW'(BufBytes)) begin
      repeat ((len == '0) ? 1 : int'(len)) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Ascii frame with random content and no accidental terminator
  task automatic send_ascii_frame(input int unsigned n, input bit with_end);
    logic [ByteW-1:0] prev;
    logic [ByteW-1:0] b;
    prev = '0;
    send_header(AsciiQual, AsciiLen, AsciiLen);
    for (int unsigned i = 0; i < n; i++) begin
      b = ($urandom_range(9) == 0) ? ChLf : 8'($urandom_range(255));
      if (prev == ChLf && b == ChCr) b = ~ChCr;
      send_byte(b);
      prev = b;
    end
    if (with_end) begin
      send_byte(ChLf);
      send_byte(ChCr);
    end
  endtask

  function automatic logic [ByteW-1:0] random_qualifier();
    logic [ByteW-1:0] q;
    q = 8'($urandom_range(255));
    if (q == AsciiQual) q = ~q;
    return q;
  endfunction

  // Drop valid and hold off until every predicted result has arrived
  task automatic wait_drain();
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup and access cycle, then the bus idles before the next transfer
  task automatic reg_write(input reg_idx_e idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSyncFirst:  cfg_sync_first  = val[ByteW-1:0];
      RegSyncSecond: cfg_sync_second = val[ByteW-1:0];
      default:       cfg_max_len     = val[MaxLenW-1:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second,
                              input logic [MaxLenW-1:0] max_len);
    wait_drain();
    reg_write(RegSyncFirst, DataW'(first));
    reg_write(RegSyncSecond, DataW'(second));
    reg_write(RegMaxLength, DataW'(max_len));
  endtask

  // Reset register values: sync mismatch, payload extremes, zero length, ascii end
  task automatic test_directed_frames();
    // a repeated first sync in the second slot is not checked again
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    send_header(8'h00, 8'd2, 8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    // zero length swallows the next byte, even a sync byte
    send_header(8'hFF, 8'd0, 8'd0);
    send_byte(cfg_sync_first);
    // lone LF is payload, LF then CR ends the frame
    send_header(AsciiQual, AsciiLen, AsciiLen);
    send_byte(ChLf);
    send_byte(AsciiQual);
    send_byte(ChLf);
    send_byte(ChCr);
  endtask

  // Register extremes: length limit of one, CR as first sync, full 1024 limit
  task automatic test_config_extremes();
    apply_config(ChCr, 8'hFF, 11'd1);
    send_header(8'h00, 8'd1, 8'd0);
    // empty ascii frame; its CR opens the next header
    send_header(AsciiQual, AsciiLen, AsciiLen);
    send_byte(ChLf);
    send_byte(ChCr);
    send_byte(cfg_sync_second);
    send_byte(AsciiQual);
    send_byte(AsciiLen);
    send_byte(AsciiLen + 8'd1);
    send_header(8'h7F, 8'd0, 8'd0);
    send_byte(ChCr);
    apply_config(8'h00, 8'h00, 11'd1024);
    send_binary_frame(8'hFF, 16'd3);
    send_header(8'h80, 8'h00, 8'h04);
  endtask

  // Long receiver hold while bytes keep coming, then a full drain before more
  task automatic test_stall_and_drain();
    hold_starts++;
    send_binary_frame(random_qualifier(), 16'd120);
    wait_drain();
    send_binary_frame(random_qualifier(), 16'd20);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [ByteW-1:0] first,
                                     input logic [ByteW-1:0] second,
                                     input logic [MaxLenW-1:0] max_len,
                                     input int unsigned target);
    int unsigned start;
    int unsigned noise;
    int unsigned sel;
    int unsigned n;
    logic [ByteW-1:0] b;
    logic [LenW-1:0] len;
    apply_config(first, second, max_len);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = bytes_sent;
    noise = 0;
    while (bytes_sent - start - noise < target) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        // mostly short frames, some long, some over the limits
        sel = $urandom_range(99);
        if (sel < 70) len = LenW'($urandom_range(12));
        else if (sel < 85) len = LenW'($urandom_range(90, 13));
        else if (sel < 95) len = LenW'(cfg_max_len) + LenW'($urandom_range(2));
        else len = LenW'($urandom_range(65535, 1025));
        send_binary_frame(random_qualifier(), len);
      end else if (sel < 75) begin
        send_ascii_frame($urandom_range(24), 1'b1);
      end else if (sel < 88) begin
        case ($urandom_range(3))
          0: begin
            b = ($urandom_range(1) == 1) ? cfg_sync_first : 8'($urandom_range(255));
            if (b == cfg_sync_second) b = ~b;
            send_byte(cfg_sync_first);
            send_byte(b);
          end
          1: send_header(AsciiQual, ($urandom_range(1) == 1) ? AsciiLen : 8'($urandom_range(255)),
                         8'($urandom_range(255)));
          2: begin
            send_byte(cfg_sync_first);
            send_byte(cfg_sync_second);
            send_byte(random_qualifier());
          end
          default: send_ascii_frame($urandom_range(6, 1), 1'b0);
        endcase
      end else begin
        n = $urandom_range(6, 1);
        noise += n;
        repeat (n) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Ascii frame that runs past the buffer and aborts
  task automatic test_ascii_overflow();
    wait_drain();
    while (dfr_phase != PhHunt) begin
      send_byte(~cfg_sync_first);
      wait_drain();
    end
    send_ascii_frame(BufBytes + 6, 1'b0);
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 24;
    recv_idle_pct = 47;
    test_directed_frames();
    test_config_extremes();
    test_stall_and_drain();
    test_random_traffic(24, 47, 8'h00, 8'hFF, 11'd1024, 250);
    test_random_traffic(47, 24, 8'hFF, 8'h00, 11'($urandom_range(64, 8)), 250);
    test_random_traffic(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        11'($urandom_range(1024, 16)), 150);
    test_ascii_overflow();

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sync_length_frame_deframer_unit.f @@
rtl/core/slfd_pkg.sv
rtl/core/slfd_if.sv
rtl/core/sync_length_frame_deframer_unit.sv
verif/tb_top.sv
